// ----- hw/rtl/bcbr_pkg.sv -----
package bcbr_pkg;

   localparam int BUF_BYTES = 4096;
   localparam int ADDR_W    = $clog2(BUF_BYTES);
   localparam int POS_W     = ADDR_W + 1;
   localparam int MAX_BITS  = 32;
   localparam int NB_W      = 6;
   localparam int BYTE_W    = 8;

   // request opcodes as they arrive on the port
   localparam logic [2:0] OP_LOAD  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_RAW   = 3'd2;
   localparam logic [2:0] OP_BLOCK = 3'd3;
   localparam logic [2:0] OP_ZEROS = 3'd4;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_LOAD,
      KIND_START,
      KIND_READ,
      KIND_ZEROS
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_END   = 2'd1,
      STAT_FAULT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STEP,
      ST_RESP
   } state_type;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   idx;
      logic [BYTE_W-1:0]   val;
      logic [POS_W-1:0]    len;
      logic [NB_W-1:0]     nbits;
      logic [NB_W-1:0]     bsize;
      logic                end_ok;
   } cmd_type;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   wr_data;
   } ram_req_type;

   function automatic logic [MAX_BITS-1:0] low_mask(input logic [NB_W-1:0] n);
      logic [MAX_BITS-1:0] m;
      if (n >= NB_W'(MAX_BITS)) begin
         m = '1;
      end else begin
         m = (MAX_BITS'(1) << n) - MAX_BITS'(1);
      end
      return m;
   endfunction

   function automatic logic [BYTE_W-1:0] low_mask8(input logic [3:0] n);
      logic [BYTE_W-1:0] m;
      if (n >= 4'd8) begin
         m = '1;
      end else begin
         m = (BYTE_W'(1) << n) - BYTE_W'(1);
      end
      return m;
   endfunction

endpackage

// ----- hw/rtl/bcbr_ram.sv -----
module bcbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write or read one entry, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bcbr_front.sv -----
module bcbr_front (
   input  logic                                req_valid,
   input  logic [2:0]                          req_op,
   input  logic [bcbr_pkg::ADDR_W-1:0]         req_byte_index,
   input  logic [bcbr_pkg::BYTE_W-1:0]         req_byte_value,
   input  logic [bcbr_pkg::POS_W-1:0]          req_length,
   input  logic [bcbr_pkg::NB_W-1:0]           req_num_bits,
   input  logic [bcbr_pkg::NB_W-1:0]           req_block_size,
   input  logic                                req_end_ok,
   input  logic                                q_full,
   output logic                                q_push,
   output bcbr_pkg::cmd_type                   q_cmd
);
   import bcbr_pkg::*;

   logic [NB_W-1:0] nb;
   logic [NB_W-1:0] bs;

   // clamp widths and pick the first block width
   always_comb begin
      nb = (req_num_bits > NB_W'(MAX_BITS)) ? NB_W'(MAX_BITS) : req_num_bits;
      if (req_block_size == '0 || req_block_size > nb || nb < NB_W'(3)) begin
         bs = nb;
      end else begin
         bs = req_block_size;
      end
   end

   // classify the transaction
   always_comb begin
      q_cmd.idx    = req_byte_index;
      q_cmd.val    = req_byte_value;
      q_cmd.len    = (req_length > POS_W'(BUF_BYTES)) ? POS_W'(BUF_BYTES) : req_length;
      q_cmd.nbits  = nb;
      q_cmd.bsize  = bs;
      q_cmd.end_ok = req_end_ok;
      unique case (req_op)
         OP_LOAD:  q_cmd.kind = KIND_LOAD;
         OP_START: q_cmd.kind = KIND_START;
         OP_RAW: begin
            q_cmd.kind  = (nb == '0) ? KIND_NOP : KIND_READ;
            q_cmd.bsize = nb;
         end
         OP_BLOCK: q_cmd.kind = (nb == '0) ? KIND_NOP : KIND_READ;
         OP_ZEROS: q_cmd.kind = KIND_ZEROS;
         default:  q_cmd.kind = KIND_NOP;
      endcase
   end

   assign q_push = req_valid && !q_full;

endmodule

// ----- hw/rtl/bcbr_queue.sv -----
module bcbr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bcbr_pkg::cmd_type cmd_in,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output bcbr_pkg::cmd_type cmd_out
);
   import bcbr_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold queued transactions
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign cmd_out = entry_ff[rd_ptr_ff];

endmodule

// ----- hw/rtl/bcbr_exec.sv -----
module bcbr_exec (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  bcbr_pkg::cmd_type             q_cmd,
   output logic                          q_pop,
   output bcbr_pkg::ram_req_type         ram_req,
   input  logic [bcbr_pkg::BYTE_W-1:0]   ram_rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bcbr_pkg::MAX_BITS-1:0] rsp_value_out,
   output logic [1:0]                    rsp_status
);
   import bcbr_pkg::*;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [POS_W-1:0]      read_pos_ff, read_pos_in;
   logic [POS_W-1:0]      end_pos_ff, end_pos_in;
   logic [3:0]            left_ff, left_in;
   logic [MAX_BITS-1:0]   res_ff, res_in;
   logic [NB_W-1:0]       wpos_ff, wpos_in;
   logic [NB_W-1:0]       blk_rem_ff, blk_rem_in;
   logic [NB_W-1:0]       bs_ff, bs_in;
   logic [2:0]            blocks_ff, blocks_in;
   logic                  marker_ff, marker_in;
   status_type            fin_stat_ff, fin_stat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MAX_BITS-1:0]   rsp_value_ff, rsp_value_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  at_end;
   logic                  out_free;
   logic [NB_W-1:0]       need;
   logic                  partial;
   logic [3:0]            take;
   logic [BYTE_W-1:0]     chunk;
   logic [NB_W-1:0]       wpos_step;
   logic [NB_W-1:0]       blk_rem_step;
   logic [NB_W-1:0]       rem_step;
   logic [NB_W-1:0]       rem_now;
   logic [BYTE_W-1:0]     zbits;
   logic                  zfound;
   logic [3:0]            zpos;
   logic                  step_done;
   status_type            end_stat;

   // decode one step of the cursor against the fetched byte
   always_comb begin
      at_end   = (read_pos_ff >= end_pos_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
      end_stat = cmd_ff.end_ok ? STAT_END : STAT_FAULT;
      need     = marker_ff ? NB_W'(1) : blk_rem_ff;
      partial  = (NB_W'(left_ff) > need);
      take     = partial ? need[3:0] : left_ff;
      if (partial) begin
         chunk = (ram_rd_data >> (left_ff - need[3:0])) & low_mask8(need[3:0]);
      end else begin
         chunk = ram_rd_data & low_mask8(left_ff);
      end
      wpos_step    = wpos_ff + NB_W'(take);
      blk_rem_step = blk_rem_ff - NB_W'(take);
      rem_step     = cmd_ff.nbits - wpos_step;
      rem_now      = cmd_ff.nbits - wpos_ff;
      // find the first one bit among the unread bits
      zbits  = ram_rd_data & low_mask8(left_ff);
      zfound = 1'b0;
      zpos   = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         if (zbits[i]) begin
            zfound = 1'b1;
            zpos   = 4'(i);
         end
      end
      step_done = 1'b0;
      if (cmd_ff.kind == KIND_ZEROS) begin
         step_done = zfound;
      end else if (marker_ff) begin
         step_done = !chunk[0];
      end else begin
         step_done = (blk_rem_step == '0) && (rem_step == '0);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = (q_cmd.kind == KIND_READ || q_cmd.kind == KIND_ZEROS) ?
                          ST_FETCH : ST_RESP;
            end
         end
         ST_FETCH: state_in = at_end ? ST_RESP : ST_STEP;
         ST_STEP:  state_in = step_done ? ST_RESP : ST_FETCH;
         ST_RESP:  state_in = out_free ? ST_IDLE : ST_RESP;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in        = cmd_ff;
      read_pos_in   = read_pos_ff;
      end_pos_in    = end_pos_ff;
      left_in       = left_ff;
      res_in        = res_ff;
      wpos_in       = wpos_ff;
      blk_rem_in    = blk_rem_ff;
      bs_in         = bs_ff;
      blocks_in     = blocks_ff;
      marker_in     = marker_ff;
      fin_stat_in   = fin_stat_ff;
      q_pop         = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.addr    = read_pos_ff[ADDR_W-1:0];
      ram_req.wr_data = q_cmd.val;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               cmd_in      = q_cmd;
               res_in      = '0;
               wpos_in     = '0;
               bs_in       = q_cmd.bsize;
               blk_rem_in  = q_cmd.bsize;
               blocks_in   = '0;
               marker_in   = 1'b0;
               fin_stat_in = STAT_OK;
               if (q_cmd.kind == KIND_LOAD) begin
                  ram_req.wr_en = 1'b1;
                  ram_req.addr  = q_cmd.idx;
               end
               if (q_cmd.kind == KIND_START) begin
                  end_pos_in  = q_cmd.len;
                  read_pos_in = '0;
                  left_in     = 4'd8;
               end
            end
         end
         ST_FETCH: begin
            if (at_end) begin
               res_in      = '0;
               fin_stat_in = end_stat;
            end
         end
         ST_STEP: begin
            if (cmd_ff.kind == KIND_ZEROS) begin
               if (zfound) begin
                  res_in  = res_ff + MAX_BITS'(left_ff) - MAX_BITS'(zpos) - MAX_BITS'(1);
                  left_in = zpos;
                  if (zpos == '0) begin
                     read_pos_in = read_pos_ff + POS_W'(1);
                     left_in     = 4'd8;
                  end
               end else begin
                  res_in      = res_ff + MAX_BITS'(left_ff);
                  read_pos_in = read_pos_ff + POS_W'(1);
                  left_in     = 4'd8;
               end
            end else begin
               // consume bits from the current byte
               if (partial) begin
                  left_in = left_ff - take;
               end else begin
                  read_pos_in = read_pos_ff + POS_W'(1);
                  left_in     = 4'd8;
               end
               if (!marker_ff) begin
                  res_in     = res_ff | (MAX_BITS'(chunk) << wpos_ff[4:0]);
                  wpos_in    = wpos_step;
                  blk_rem_in = blk_rem_step;
                  if (blk_rem_step == '0 && rem_step != '0) begin
                     marker_in = 1'b1;
                  end
               end else if (!chunk[0]) begin
                  // stop marker: extend the last block's top bit
                  if (res_ff[5'(wpos_ff - NB_W'(1))]) begin
                     res_in = res_ff | (low_mask(cmd_ff.nbits) & ~low_mask(wpos_ff));
                  end
               end else begin
                  // continue marker: pick the next block width
                  blocks_in = blocks_ff + 3'd1;
                  if (blocks_ff + 3'd1 >= 3'd4) begin
                     bs_in = cmd_ff.nbits;
                  end else if (bs_ff > NB_W'(2)) begin
                     bs_in = bs_ff >> 1;
                  end
                  blk_rem_in = (bs_in > rem_now) ? rem_now : bs_in;
                  marker_in  = 1'b0;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = fin_stat_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         read_pos_ff  <= '0;
         end_pos_ff   <= '0;
         left_ff      <= 4'd8;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_pos_ff  <= read_pos_in;
         end_pos_ff   <= end_pos_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold working payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      res_ff        <= res_in;
      wpos_ff       <= wpos_in;
      blk_rem_ff    <= blk_rem_in;
      bs_ff         <= bs_in;
      blocks_ff     <= blocks_in;
      marker_ff     <= marker_in;
      fin_stat_ff   <= fin_stat_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ----- hw/rtl/block_compressed_bit_reader.sv -----
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  op, byte_index, byte_value, length,
//                                           num_bits, block_size, end_ok
// rsp_      out        rsp_valid/rsp_stall  value_out, status
//
// Load, start and no-op transactions pass from idle straight to the result state.
// Reads and zero counts alternate a fetch and a step state, the fetch
// reading the single-port byte memory with its registered read; a step covers one
// byte of a zero count, or the bits of one block or marker that lie in one byte.
// A two-entry queue lets requests arrive while the executer is busy.
// Reset is synchronous and active high and leaves the buffer as it is; a stalled
// result holds in the output register and the executer waits on it.
module block_compressed_bit_reader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [11:0] req_byte_index,
   input  logic [7:0]  req_byte_value,
   input  logic [12:0] req_length,
   input  logic [5:0]  req_num_bits,
   input  logic [5:0]  req_block_size,
   input  logic        req_end_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value_out,
   output logic [1:0]  rsp_status
);
   import bcbr_pkg::*;

   cmd_type             front_cmd;
   cmd_type             back_cmd;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_empty;
   ram_req_type         ram_req;
   logic [BYTE_W-1:0]   ram_rd_data;

   bcbr_front u_front (
      .req_valid      (req_valid),
      .req_op         (req_op),
      .req_byte_index (req_byte_index),
      .req_byte_value (req_byte_value),
      .req_length     (req_length),
      .req_num_bits   (req_num_bits),
      .req_block_size (req_block_size),
      .req_end_ok     (req_end_ok),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (front_cmd)
   );

   bcbr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (front_cmd),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .cmd_out (back_cmd)
   );

   bcbr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUF_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .addr    (ram_req.addr),
      .wr_data (ram_req.wr_data),
      .rd_data (ram_rd_data)
   );

   bcbr_exec u_exec (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_cmd         (back_cmd),
      .q_pop         (q_pop),
      .ram_req       (ram_req),
      .ram_rd_data   (ram_rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status)
   );

   assign req_stall = q_full;

`ifndef SYNTHESIS
   // an end or fault transaction carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_value_out == '0)
      else $error("nonzero value on end or fault");

   // no status code beyond fault
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status code");

   // the queue never takes a transaction while it is full
   assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");
`endif

endmodule

// ----- sim/bcbr_checker.sv -----
`timescale 1ns / 100ps

module bcbr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [11:0] req_byte_index,
   input  logic [7:0]  req_byte_value,
   input  logic [12:0] req_length,
   input  logic [5:0]  req_num_bits,
   input  logic [5:0]  req_block_size,
   input  logic        req_end_ok,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_value_out,
   input  logic [1:0]  rsp_status,
   output int          pending,
   output int          fail_count
);
   import bcbr_pkg::*;

   typedef struct {
      logic [31:0] value;
      status_type  status;
   } answer_type;

   // shadow of the block's buffer and cursor
   logic [7:0]  shadow_mem [0:BUF_BYTES-1];
   int unsigned cur_pos;
   int unsigned stop_pos;
   int unsigned bits_avail;

   answer_type  answer_q [$];

   function automatic logic [31:0] ones_below(input int unsigned n);
      logic [32:0] m;
      m = (33'h1 << n) - 33'h1;
      return m[31:0];
   endfunction

   function automatic status_type out_of_data(input bit eok);
      return eok ? STAT_END : STAT_FAULT;
   endfunction

   // pull n bits, MSB-first per byte, packed from the low end
   function automatic status_type pull_bits(input int unsigned n, input bit eok,
                                             output logic [31:0] v);
      int unsigned rem;
      int unsigned shift;
      int unsigned avail;
      logic [31:0] acc;
      logic [31:0] b;
      rem   = n;
      shift = 0;
      acc   = '0;
      v     = '0;
      while (rem != 0) begin
         if (cur_pos >= stop_pos) return out_of_data(eok);
         avail = bits_avail;
         if (avail == 0 || avail > 8) avail = 8;
         if (avail > rem) begin
            b = 32'(shadow_mem[cur_pos]) >> (avail - rem);
            acc |= (b & ones_below(rem)) << shift;
            bits_avail = avail - rem;
            rem = 0;
         end else begin
            b = 32'(shadow_mem[cur_pos]) & ones_below(avail);
            acc |= b << shift;
            shift += avail;
            rem -= avail;
            cur_pos++;
            bits_avail = 8;
         end
      end
      v = acc;
      return STAT_OK;
   endfunction

   // blocks halve while over 2 bits; a zero marker sign-fills the rest
   function automatic status_type pull_blocks(input int unsigned n, input int unsigned bsz,
                                               input bit eok, output logic [31:0] v);
      int unsigned rem;
      int unsigned nblk;
      int unsigned take;
      int unsigned bs;
      logic [31:0] res;
      logic [31:0] blk;
      logic [31:0] mark;
      status_type  st;
      rem  = n;
      nblk = 0;
      res  = '0;
      bs   = bsz;
      v    = '0;
      if (bs == 0 || bs > n) bs = n;
      if (bs == n || n < 3) return pull_bits(n, eok, v);
      while (rem != 0) begin
         take = (bs > rem) ? rem : bs;
         st = pull_bits(take, eok, blk);
         if (st != STAT_OK) return st;
         res |= blk << (n - rem);
         rem -= take;
         if (rem != 0) begin
            st = pull_bits(1, eok, mark);
            if (st != STAT_OK) return st;
            if (mark == 0) begin
               if (blk[take-1]) res |= ones_below(rem) << (n - rem);
               rem = 0;
            end
         end
         nblk++;
         if (nblk >= 4) bs = n;
         else if (bs > 2) bs = bs >> 1;
      end
      v = res;
      return STAT_OK;
   endfunction

   function automatic status_type tally_zeros(input bit eok, output logic [31:0] v);
      int unsigned count;
      logic [7:0]  b;
      count = 0;
      v = '0;
      while (cur_pos < stop_pos) begin
         b = shadow_mem[cur_pos];
         if (bits_avail == 0 || bits_avail > 8) bits_avail = 8;
         while (bits_avail != 0) begin
            bits_avail--;
            if (b[bits_avail]) begin
               if (bits_avail == 0) begin
                  cur_pos++;
                  bits_avail = 8;
               end
               v = count;
               return STAT_OK;
            end
            count++;
         end
         cur_pos++;
         bits_avail = 8;
      end
      return out_of_data(eok);
   endfunction

   function automatic answer_type decode_request(input logic [2:0] op, input logic [11:0] idx,
                                                 input logic [7:0] val, input logic [12:0] len,
                                                 input logic [5:0] nb_in, input logic [5:0] bs,
                                                 input bit eok);
      answer_type  a;
      int unsigned nb;
      a.value  = '0;
      a.status = STAT_OK;
      nb = (nb_in > MAX_BITS) ? MAX_BITS : nb_in;
      case (op)
         OP_LOAD: shadow_mem[idx] = val;
         OP_START: begin
            stop_pos   = (len > BUF_BYTES) ? BUF_BYTES : len;
            cur_pos    = 0;
            bits_avail = 8;
         end
         OP_RAW:   a.status = pull_bits(nb, eok, a.value);
         OP_BLOCK: if (nb != 0) a.status = pull_blocks(nb, 32'(bs), eok, a.value);
         OP_ZEROS: a.status = tally_zeros(eok, a.value);
         default: ;
      endcase
      if (a.status != STAT_OK) a.value = '0;
      return a;
   endfunction

   initial begin
      for (int i = 0; i < BUF_BYTES; i++) shadow_mem[i] = '0;
      cur_pos    = 0;
      stop_pos   = 0;
      bits_avail = 8;
      fail_count = 0;
   end

   assign pending = answer_q.size();

   // predict on each accepted request, compare on each accepted result
   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            answer_q.push_back(decode_request(req_op, req_byte_index, req_byte_value,
                                              req_length, req_num_bits, req_block_size,
                                              req_end_ok));
         end
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               $error("unexpected result transaction: value_out %h status %0d",
                      rsp_value_out, rsp_status);
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_value_out !== want.value) begin
                  $error("value_out: expected %h, actual %h", want.value, rsp_value_out);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import bcbr_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int TARGET_ITEMS = 1950;
   localparam int IDLE_LIMIT = 8000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_op;
   logic [11:0] req_byte_index;
   logic [7:0]  req_byte_value;
   logic [12:0] req_length;
   logic [5:0]  req_num_bits;
   logic [5:0]  req_block_size;
   logic        req_end_ok;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_value_out;
   logic [1:0]  rsp_status;
   int          pending;
   int          fail_count;

   int          sent;
   int          burst_left;
   int          idle_cycles = 0;
   int          stall_mode = 0;
   bit          finished;

   block_compressed_bit_reader uut (.*);

   bcbr_checker check (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // result side: stall pattern switches among four modes at random
   always @(posedge clock) begin
      if (($urandom % 300) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom % 4) == 0;
         2: rsp_stall <= ($urandom % 2) == 0;
         default: rsp_stall <= ($urandom % 16) < 13;
      endcase
   end

   // end the run after a long stretch with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT && !finished) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // send one transaction; load: a=index b=value, start: a=length, reads: a=width b=block
   task automatic issue(input logic [2:0] op, input int a, input int b, input bit eok);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_op         <= op;
      req_byte_index <= (op == OP_LOAD) ? 12'(a) : 12'($urandom);
      req_byte_value <= (op == OP_LOAD) ? 8'(b) : 8'($urandom);
      req_length     <= (op == OP_START) ? 13'(a) : 13'($urandom);
      req_num_bits   <= (op == OP_RAW || op == OP_BLOCK) ? 6'(a) : 6'($urandom);
      req_block_size <= (op == OP_RAW || op == OP_BLOCK) ? 6'(b) : 6'($urandom);
      req_end_ok     <= eok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // one phase: fill a prefix, start, then a run of reads, spare ops and stray loads
   task automatic run_phase(input bit over_len);
      int fill;
      int budget;
      int cost;
      int nreads;
      int pick;
      int nb;
      logic [2:0] op;
      fill = ($urandom % 10 == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      budget = 8 * fill;
      for (int i = 0; i < fill; i++) begin
         if (over_len) issue(OP_LOAD, i, $urandom_range(1, 255), 1'b0);
         else if ($urandom % 3 == 0) issue(OP_LOAD, i, ($urandom % 2) ? 0 : (1 << ($urandom % 8)), 1'b0);
         else issue(OP_LOAD, i, $urandom_range(0, 255), 1'b0);
      end
      issue(OP_START, over_len ? $urandom_range(fill + 1, 8191) : $urandom_range(0, fill),
            $urandom, 1'($urandom));
      nreads = $urandom_range(8, 40);
      for (int i = 0; i < nreads; i++) begin
         pick = $urandom_range(0, 99);
         nb = ($urandom % 10 == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
         if (pick < 30) begin
            op = OP_RAW;
            cost = (nb > 32) ? 32 : nb;
         end else if (pick < 70) begin
            op = OP_BLOCK;
            cost = ((nb > 32) ? 32 : nb) + 4;
         end else if (pick < 88) begin
            op = OP_ZEROS;
            cost = 16;
         end else if (pick < 94) begin
            op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            cost = 0;
         end else begin
            // stray load above the prefix in use
            issue(OP_LOAD, $urandom_range(fill, BUF_BYTES - 1), $urandom, 1'($urandom));
            continue;
         end
         if (over_len) begin
            if (cost > budget) break;
            budget -= cost;
         end
         issue(op, nb, ($urandom % 2) ? $urandom_range(0, 8) : $urandom_range(0, 63),
               1'($urandom));
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= OP_LOAD;
      req_byte_index <= '0;
      req_byte_value <= '0;
      req_length     <= '0;
      req_num_bits   <= '0;
      req_block_size <= '0;
      req_end_ok     <= 1'b0;
      sent           = 0;
      burst_left     = 0;
      finished       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty buffer, extremes of width and block size, spare ops
      issue(OP_LOAD, 0, 'h00, 1'b0);
      issue(OP_LOAD, 1, 'hFF, 1'b0);
      issue(OP_LOAD, 2, 'hA5, 1'b0);
      issue(OP_LOAD, 3, 'h80, 1'b0);
      issue(OP_LOAD, BUF_BYTES - 1, 'h5A, 1'b0);
      issue(OP_START, 0, 0, 1'b0);
      issue(OP_RAW, 8, 0, 1'b0);
      issue(OP_ZEROS, 0, 0, 1'b1);
      issue(OP_START, 4, 0, 1'b0);
      issue(OP_RAW, 0, 0, 1'b0);
      issue(OP_SPARE_LO, 0, 0, 1'b0);
      issue(OP_SPARE_MID, 0, 0, 1'b1);
      issue(OP_SPARE_HI, 0, 0, 1'b0);
      issue(OP_BLOCK, 2, 1, 1'b0);
      issue(OP_BLOCK, 0, 5, 1'b0);
      issue(OP_BLOCK, 12, 40, 1'b0);
      issue(OP_START, 4, 0, 1'b0);
      issue(OP_BLOCK, 63, 3, 1'b1);
      issue(OP_START, 4, 0, 1'b0);
      issue(OP_BLOCK, 16, 0, 1'b0);
      issue(OP_BLOCK, 10, 10, 1'b0);
      issue(OP_START, 8191, 0, 1'b0);
      issue(OP_RAW, 8, 0, 1'b0);
      issue(OP_ZEROS, 0, 0, 1'b0);
      issue(OP_START, BUF_BYTES, 0, 1'b0);
      issue(OP_RAW, 32, 0, 1'b0);

      // random phases; hold off once until the block is empty
      for (int ph = 0; sent < TARGET_ITEMS; ph++) begin
         if (ph == 5) drain();
         run_phase(($urandom % 4) == 0);
      end

      drain();
      finished = 1'b1;
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
